FILE: rtl/segmented_lru_eviction_defines.svh
// ---------------------------------------------------------------------------
// Segmented LRU eviction: assertion macros
// Shared property wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef SEGMENTED_LRU_EVICTION_DEFINES_SVH
`define SEGMENTED_LRU_EVICTION_DEFINES_SVH

// check a property outside reset
`define SLRU_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// check a property at every edge, reset included
`define SLRU_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/slru_pkg.sv
// ---------------------------------------------------------------------------
// Segmented LRU eviction package
// Sizes, request and status codes, list ends and controller states.
// ---------------------------------------------------------------------------
`default_nettype none

package slru_pkg;

   localparam int ENTRIES    = 256;
   localparam int ENTRY_BITS = $clog2(ENTRIES);
   localparam int KEY_BITS   = 32;
   localparam int MAX_EVICT  = 32;
   localparam int CNT_BITS   = $clog2(MAX_EVICT + 1);
   localparam int LINK_BITS  = 2 * ENTRY_BITS;

   typedef enum logic [2:0] {
      REQ_INSERT = 3'd0,
      REQ_ACCESS = 3'd1,
      REQ_TOUCH  = 3'd2,
      REQ_EVICT  = 3'd3,
      REQ_CLEAR  = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      ST_INSERTED  = 3'd0,
      ST_REFRESHED = 3'd1,
      ST_PROMOTED  = 3'd2,
      ST_MISS      = 3'd3,
      ST_FULL      = 3'd4,
      ST_EVICTED   = 3'd5,
      ST_NOTHING   = 3'd6,
      ST_CLEARED   = 3'd7
   } status_type;

   typedef struct packed {
      logic [ENTRY_BITS-1:0] head;
      logic [ENTRY_BITS-1:0] tail;
      logic                  busy;
   } lru_ends_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_ULINK_RD,
      S_ULINK_DAT,
      S_ULINK_W2,
      S_PUSH1,
      S_PUSH2,
      S_EV_SEL,
      S_EV_OUT,
      S_EMIT
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/slru_ram.sv
// ---------------------------------------------------------------------------
// Generic RAM
// One write port with bit mask, one read port with registered data.
// ---------------------------------------------------------------------------
`default_nettype none

module slru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_mask,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= (mem[wr_addr] & ~wr_mask) | (wr_data & wr_mask);
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/segmented_lru_eviction.sv
// Insert, access and touch scan the key memory until a hit; a miss, a full table or a new
// insert scans every slot. Evict selects a tail, unlinks it and returns it, one result beat
// per removed block; clear, unknown and empty evicts go straight to their single result beat.
// One request at a time; the next is accepted the cycle after its last beat is issued,
// and a stalled result beat holds the block. The key scan sets the rate.
// Reset empties both lists and clears all valid bits at once; promotion resets to on.
// ---------------------------------------------------------------------------
// Segmented LRU eviction
// Two LRU lists, probation and protected, linked through slot memories.
// ---------------------------------------------------------------------------
`default_nettype none

module segmented_lru_eviction (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_type,
   input  wire logic [31:0] req_block_id,
   input  wire logic [5:0]  req_evict_count,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_evicted_id,
   output logic             rsp_from_protected,
   output logic             rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic        csr_wr_data
);

   localparam int EB = slru_pkg::ENTRY_BITS;
   localparam int KB = slru_pkg::KEY_BITS;
   localparam int CB = slru_pkg::CNT_BITS;
   localparam int LB = slru_pkg::LINK_BITS;

   slru_pkg::state_type    state_ff, state_in;
   slru_pkg::lru_ends_type probl_ff, probl_in, protl_ff, protl_in, cur, cur_n;
   slru_pkg::status_type   status_ff, status_in;
   logic [slru_pkg::ENTRIES-1:0] valid_ff, valid_in;
   logic          promote_ff, promote_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff, rsp_status_in;
   logic [31:0]   rsp_id_ff, rsp_id_in;
   logic          rsp_prot_ff, rsp_prot_in, rsp_last_ff, rsp_last_in;
   logic [2:0]    typ_ff, typ_in;
   logic [KB-1:0] key_ff, key_in, evkey_ff, evkey_in;
   logic [CB-1:0] cnt_ff, cnt_in, k_ff, k_in, cnt_sat;
   logic [EB-1:0] slot_ff, slot_in, free_ff, free_in, cmp_idx_ff, cmp_idx_in;
   logic [EB-1:0] pptr_ff, pptr_in, nptr_ff, nptr_in, oldhead_ff, oldhead_in;
   logic [EB:0]   scan_ff, scan_in;
   logic          sprot_ff, sprot_in, free_found_ff, free_found_in, hit_ff, hit_in;
   logic          cmp_vld_ff, cmp_vld_in, at_tail_ff, at_tail_in;
   logic          cur_upd, out_free, ev_last, at_head, at_tail;

   logic          key_we, link_we;
   logic [EB-1:0] key_wa, key_ra, link_wa;
   logic [KB:0]   key_wd, key_rd;
   logic [LB-1:0] link_wd, link_wmask, link_rd;
   logic [EB-1:0] rd_prev, rd_next;

   slru_ram #(.WIDTH(KB + 1), .DEPTH(slru_pkg::ENTRIES)) u_key_ram (
      .clock(clock), .wr_en(key_we), .wr_addr(key_wa), .wr_mask({(KB + 1){1'b1}}),
      .wr_data(key_wd), .rd_addr(key_ra), .rd_data(key_rd)
   );

   slru_ram #(.WIDTH(LB), .DEPTH(slru_pkg::ENTRIES)) u_link_ram (
      .clock(clock), .wr_en(link_we), .wr_addr(link_wa), .wr_mask(link_wmask),
      .wr_data(link_wd), .rd_addr(slot_ff), .rd_data(link_rd)
   );

   assign rd_prev = link_rd[LB-1:EB];
   assign rd_next = link_rd[EB-1:0];
   assign key_ra  = (state_ff == slru_pkg::S_SCAN) ? scan_ff[EB-1:0] : slot_ff;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign cur = sprot_ff ? protl_ff : probl_ff;
   assign cnt_sat = ({1'b0, req_evict_count} > 7'(slru_pkg::MAX_EVICT)) ?
                    CB'(slru_pkg::MAX_EVICT) : CB'(req_evict_count);

   always_comb begin
      state_in      = state_ff;
      probl_in      = probl_ff;
      protl_in      = protl_ff;
      cur_n         = cur;
      cur_upd       = 1'b0;
      status_in     = status_ff;
      valid_in      = valid_ff;
      promote_in    = csr_wr_en ? csr_wr_data : promote_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_id_in     = rsp_id_ff;
      rsp_prot_in   = rsp_prot_ff;
      rsp_last_in   = rsp_last_ff;
      typ_in        = typ_ff;
      key_in        = key_ff;
      evkey_in      = evkey_ff;
      cnt_in        = cnt_ff;
      k_in          = k_ff;
      slot_in       = slot_ff;
      free_in       = free_ff;
      cmp_idx_in    = cmp_idx_ff;
      pptr_in       = pptr_ff;
      nptr_in       = nptr_ff;
      oldhead_in    = oldhead_ff;
      scan_in       = scan_ff;
      sprot_in      = sprot_ff;
      free_found_in = free_found_ff;
      hit_in        = hit_ff;
      cmp_vld_in    = 1'b0;
      at_tail_in    = at_tail_ff;
      req_ready     = 1'b0;
      key_we        = 1'b0;
      key_wa        = slot_ff;
      key_wd        = {sprot_ff, key_ff};
      link_we       = 1'b0;
      link_wa       = slot_ff;
      link_wd       = '0;
      link_wmask    = '0;
      at_head       = (cur.head == slot_ff);
      at_tail       = (cur.tail == slot_ff);
      ev_last       = (CB'(k_ff + 1'b1) == cnt_ff) || (!probl_ff.busy && !protl_ff.busy);

      case (state_ff)
         slru_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               typ_in        = req_type;
               key_in        = req_block_id[KB-1:0];
               cnt_in        = cnt_sat;
               k_in          = '0;
               scan_in       = '0;
               free_found_in = 1'b0;
               hit_in        = 1'b0;
               case (req_type)
                  slru_pkg::REQ_INSERT, slru_pkg::REQ_ACCESS, slru_pkg::REQ_TOUCH: begin
                     state_in = slru_pkg::S_SCAN;
                  end
                  slru_pkg::REQ_EVICT: begin
                     if (cnt_sat == '0 || (!probl_ff.busy && !protl_ff.busy)) begin
                        status_in = slru_pkg::ST_NOTHING;
                        state_in  = slru_pkg::S_EMIT;
                     end else begin
                        state_in = slru_pkg::S_EV_SEL;
                     end
                  end
                  slru_pkg::REQ_CLEAR: begin
                     valid_in  = '0;
                     probl_in  = '0;
                     protl_in  = '0;
                     status_in = slru_pkg::ST_CLEARED;
                     state_in  = slru_pkg::S_EMIT;
                  end
                  default: begin
                     status_in = slru_pkg::ST_NOTHING;
                     state_in  = slru_pkg::S_EMIT;
                  end
               endcase
            end
         end
         slru_pkg::S_SCAN: begin
            if (scan_ff != (EB + 1)'(slru_pkg::ENTRIES)) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_ff[EB-1:0];
               scan_in    = scan_ff + 1'b1;
            end
            if (cmp_vld_ff) begin
               if (valid_ff[cmp_idx_ff] && key_rd[KB-1:0] == key_ff) begin
                  hit_in   = 1'b1;
                  slot_in  = cmp_idx_ff;
                  sprot_in = key_rd[KB];
                  state_in = slru_pkg::S_DECIDE;
               end else begin
                  if (!valid_ff[cmp_idx_ff] && !free_found_ff) begin
                     free_in       = cmp_idx_ff;
                     free_found_in = 1'b1;
                  end
                  if (cmp_idx_ff == EB'(slru_pkg::ENTRIES - 1)) begin
                     state_in = slru_pkg::S_DECIDE;
                  end
               end
            end
         end
         slru_pkg::S_DECIDE: begin
            if (hit_ff) begin
               if (typ_ff == slru_pkg::REQ_ACCESS && promote_ff && !sprot_ff) begin
                  status_in = slru_pkg::ST_PROMOTED;
                  state_in  = slru_pkg::S_ULINK_DAT;
               end else if (cur.busy && at_head) begin
                  status_in = slru_pkg::ST_REFRESHED;
                  state_in  = slru_pkg::S_EMIT;
               end else begin
                  status_in = slru_pkg::ST_REFRESHED;
                  state_in  = slru_pkg::S_ULINK_DAT;
               end
            end else if (typ_ff == slru_pkg::REQ_INSERT) begin
               if (free_found_ff) begin
                  key_we            = 1'b1;
                  key_wa            = free_ff;
                  key_wd            = {!promote_ff, key_ff};
                  valid_in[free_ff] = 1'b1;
                  slot_in           = free_ff;
                  sprot_in          = !promote_ff;
                  status_in         = slru_pkg::ST_INSERTED;
                  state_in          = slru_pkg::S_PUSH1;
               end else begin
                  status_in = slru_pkg::ST_FULL;
                  state_in  = slru_pkg::S_EMIT;
               end
            end else begin
               status_in = slru_pkg::ST_MISS;
               state_in  = slru_pkg::S_EMIT;
            end
         end
         slru_pkg::S_ULINK_RD: begin
            state_in = slru_pkg::S_ULINK_DAT;
         end
         slru_pkg::S_ULINK_DAT: begin
            cur_upd    = 1'b1;
            pptr_in    = rd_prev;
            nptr_in    = rd_next;
            at_tail_in = at_tail;
            if (at_head && at_tail) begin
               cur_n = '0;
            end else begin
               if (at_head) begin
                  cur_n.head = rd_next;
               end else begin
                  link_we    = 1'b1;
                  link_wa    = rd_prev;
                  link_wd    = {{EB{1'b0}}, rd_next};
                  link_wmask = {{EB{1'b0}}, {EB{1'b1}}};
               end
               if (at_tail) begin
                  cur_n.tail = rd_prev;
               end
            end
            if (typ_ff == slru_pkg::REQ_EVICT) begin
               evkey_in          = key_rd[KB-1:0];
               valid_in[slot_ff] = 1'b0;
            end
            state_in = slru_pkg::S_ULINK_W2;
         end
         slru_pkg::S_ULINK_W2: begin
            if (!at_tail_ff) begin
               link_we    = 1'b1;
               link_wa    = nptr_ff;
               link_wd    = {pptr_ff, {EB{1'b0}}};
               link_wmask = {{EB{1'b1}}, {EB{1'b0}}};
            end
            if (typ_ff == slru_pkg::REQ_EVICT) begin
               state_in = slru_pkg::S_EV_OUT;
            end else begin
               if (status_ff == slru_pkg::ST_PROMOTED) begin
                  key_we   = 1'b1;
                  key_wd   = {1'b1, key_ff};
                  sprot_in = 1'b1;
               end
               state_in = slru_pkg::S_PUSH1;
            end
         end
         slru_pkg::S_PUSH1: begin
            cur_upd = 1'b1;
            link_we = 1'b1;
            if (!cur.busy) begin
               cur_n      = '{head: slot_ff, tail: slot_ff, busy: 1'b1};
               link_wd    = {slot_ff, {EB{1'b0}}};
               link_wmask = {{EB{1'b1}}, {EB{1'b0}}};
               state_in   = slru_pkg::S_EMIT;
            end else begin
               link_wd    = {slot_ff, cur.head};
               link_wmask = '1;
               oldhead_in = cur.head;
               cur_n.head = slot_ff;
               state_in   = slru_pkg::S_PUSH2;
            end
         end
         slru_pkg::S_PUSH2: begin
            link_we    = 1'b1;
            link_wa    = oldhead_ff;
            link_wd    = {slot_ff, {EB{1'b0}}};
            link_wmask = {{EB{1'b1}}, {EB{1'b0}}};
            state_in   = slru_pkg::S_EMIT;
         end
         slru_pkg::S_EV_SEL: begin
            if (probl_ff.busy) begin
               sprot_in = 1'b0;
               slot_in  = probl_ff.tail;
            end else begin
               sprot_in = 1'b1;
               slot_in  = protl_ff.tail;
            end
            state_in = slru_pkg::S_ULINK_RD;
         end
         slru_pkg::S_EV_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = slru_pkg::ST_EVICTED;
               rsp_id_in     = 32'(evkey_ff);
               rsp_prot_in   = sprot_ff;
               rsp_last_in   = ev_last;
               k_in          = CB'(k_ff + 1'b1);
               state_in      = ev_last ? slru_pkg::S_IDLE : slru_pkg::S_EV_SEL;
            end
         end
         slru_pkg::S_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_id_in     = '0;
               rsp_prot_in   = 1'b0;
               rsp_last_in   = 1'b1;
               state_in      = slru_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = slru_pkg::S_IDLE;
         end
      endcase

      if (cur_upd) begin
         if (sprot_ff) begin
            protl_in = cur_n;
         end else begin
            probl_in = cur_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= slru_pkg::S_IDLE;
         probl_ff     <= '0;
         protl_ff     <= '0;
         valid_ff     <= '0;
         promote_ff   <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         probl_ff     <= probl_in;
         protl_ff     <= protl_in;
         valid_ff     <= valid_in;
         promote_ff   <= promote_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_id_ff     <= rsp_id_in;
      rsp_prot_ff   <= rsp_prot_in;
      rsp_last_ff   <= rsp_last_in;
      typ_ff        <= typ_in;
      key_ff        <= key_in;
      evkey_ff      <= evkey_in;
      cnt_ff        <= cnt_in;
      k_ff          <= k_in;
      slot_ff       <= slot_in;
      free_ff       <= free_in;
      cmp_idx_ff    <= cmp_idx_in;
      pptr_ff       <= pptr_in;
      nptr_ff       <= nptr_in;
      oldhead_ff    <= oldhead_in;
      scan_ff       <= scan_in;
      sprot_ff      <= sprot_in;
      free_found_ff <= free_found_in;
      hit_ff        <= hit_in;
      cmp_vld_ff    <= cmp_vld_in;
      at_tail_ff    <= at_tail_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_evicted_id     = rsp_id_ff;
   assign rsp_from_protected = rsp_prot_ff;
   assign rsp_last           = rsp_last_ff;

endmodule

`default_nettype wire

FILE: rtl/slru_checker.sv
// ---------------------------------------------------------------------------
// Segmented LRU eviction checker
// Port-level properties of request and result beats.
// ---------------------------------------------------------------------------
`default_nettype none

`include "segmented_lru_eviction_defines.svh"

module slru_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [31:0] rsp_evicted_id,
   input wire logic        rsp_from_protected,
   input wire logic        rsp_last
);

   `SLRU_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid, "result beat after reset")

   `SLRU_ASSERT(a_one_at_a_time, clock, reset, req_valid && req_ready |=> !req_ready, "back-to-back request beat")

   `SLRU_ASSERT(a_single_last, clock, reset, rsp_valid && rsp_status != slru_pkg::ST_EVICTED |-> rsp_last && rsp_evicted_id == 32'd0 && !rsp_from_protected, "non-evict beat not final or not zero")

   `SLRU_ASSERT(a_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_evicted_id) && $stable(rsp_from_protected) && $stable(rsp_last), "stalled result beat changed")

endmodule

bind segmented_lru_eviction slru_checker u_slru_checker (.*);

`default_nettype wire

FILE: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// Segmented LRU eviction testbench
// Drives insert, access, touch, evict and clear requests with random gaps
// and response stalls. A behavioral copy of the probation and protected
// lists predicts every response beat, and each beat is checked in order.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_top;

   typedef struct {
      slru_pkg::status_type status;
      logic [31:0]          evicted_id;
      logic                 from_protected;
      logic                 last;
   } rsp_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = slru_pkg::REQ_INSERT;
   logic [31:0] req_block_id = '0;
   logic [5:0]  req_evict_count = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_evicted_id;
   logic        rsp_from_protected;
   logic        rsp_last;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   rsp_beat_type pending_rsp[$];
   logic        promote_on;
   logic        used[slru_pkg::ENTRIES];
   logic [31:0] slot_id[slru_pkg::ENTRIES];
   logic        on_prot[slru_pkg::ENTRIES];
   int          probation_q[$];
   int          protected_q[$];
   logic [31:0] key_pool[24];
   bit          calm = 1'b0;
   int          errors = 0;
   int          mismatches = 0;
   int          items_sent = 0;
   int          evicted_seen = 0;

   segmented_lru_eviction dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_block_id(req_block_id), .req_evict_count(req_evict_count),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_evicted_id(rsp_evicted_id), .rsp_from_protected(rsp_from_protected),
      .rsp_last(rsp_last), .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= calm || ($urandom_range(99) >= 35);
   end

   function automatic void add_rsp(slru_pkg::status_type st, logic [31:0] id, logic prot,
                                   logic lst);
      rsp_beat_type b;
      b.status = st;
      b.evicted_id = id;
      b.from_protected = prot;
      b.last = lst;
      pending_rsp.insert(pending_rsp.size(), b);
   endfunction

   function automatic void drop_slot(int s);
      foreach (probation_q[i]) if (probation_q[i] == s) begin
         probation_q.delete(i);
         return;
      end
      foreach (protected_q[i]) if (protected_q[i] == s) begin
         protected_q.delete(i);
         return;
      end
   endfunction

   function automatic void move_front(int s);
      drop_slot(s);
      if (on_prot[s]) protected_q.insert(0, s);
      else probation_q.insert(0, s);
   endfunction

   function automatic void empty_lists();
      foreach (used[i]) used[i] = 1'b0;
      probation_q.delete();
      protected_q.delete();
   endfunction

   function automatic int lookup(logic [31:0] id);
      for (int i = 0; i < slru_pkg::ENTRIES; i++) if (used[i] && slot_id[i] == id) return i;
      return -1;
   endfunction

   function automatic void predict_lru(logic [2:0] kind, logic [31:0] id, logic [5:0] cnt);
      int s;
      int n;
      int k;
      case (kind)
         slru_pkg::REQ_INSERT: begin
            s = lookup(id);
            if (s >= 0) begin
               move_front(s);
               add_rsp(slru_pkg::ST_REFRESHED, '0, 1'b0, 1'b1);
            end else begin
               s = -1;
               for (int i = slru_pkg::ENTRIES - 1; i >= 0; i--) if (!used[i]) s = i;
               if (s < 0) begin
                  add_rsp(slru_pkg::ST_FULL, '0, 1'b0, 1'b1);
               end else begin
                  used[s] = 1'b1;
                  slot_id[s] = id;
                  on_prot[s] = !promote_on;
                  move_front(s);
                  add_rsp(slru_pkg::ST_INSERTED, '0, 1'b0, 1'b1);
               end
            end
         end
         slru_pkg::REQ_ACCESS, slru_pkg::REQ_TOUCH: begin
            s = lookup(id);
            if (s < 0) begin
               add_rsp(slru_pkg::ST_MISS, '0, 1'b0, 1'b1);
            end else if (kind == slru_pkg::REQ_ACCESS && promote_on && !on_prot[s]) begin
               drop_slot(s);
               on_prot[s] = 1'b1;
               protected_q.insert(0, s);
               add_rsp(slru_pkg::ST_PROMOTED, '0, 1'b0, 1'b1);
            end else begin
               move_front(s);
               add_rsp(slru_pkg::ST_REFRESHED, '0, 1'b0, 1'b1);
            end
         end
         slru_pkg::REQ_EVICT: begin
            n = (cnt > slru_pkg::MAX_EVICT) ? slru_pkg::MAX_EVICT : int'(cnt);
            k = 0;
            while (k < n && (probation_q.size() + protected_q.size()) > 0) begin
               s = (probation_q.size() > 0) ? probation_q.pop_back() : protected_q.pop_back();
               used[s] = 1'b0;
               add_rsp(slru_pkg::ST_EVICTED, slot_id[s], on_prot[s], 1'b0);
               k++;
            end
            if (k == 0) add_rsp(slru_pkg::ST_NOTHING, '0, 1'b0, 1'b1);
            else pending_rsp[$].last = 1'b1;
         end
         slru_pkg::REQ_CLEAR: begin
            empty_lists();
            add_rsp(slru_pkg::ST_CLEARED, '0, 1'b0, 1'b1);
         end
         default: add_rsp(slru_pkg::ST_NOTHING, '0, 1'b0, 1'b1);
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_beat_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected beat: status %0d id %h", rsp_status, rsp_evicted_id);
         end else begin
            e = pending_rsp.pop_front();
            if (rsp_status == slru_pkg::ST_EVICTED) evicted_seen++;
            if (rsp_status !== e.status || rsp_evicted_id !== e.evicted_id ||
                rsp_from_protected !== e.from_protected || rsp_last !== e.last) begin
               errors++;
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: exp st %0d id %h prot %0b last %0b",
                           e.status, e.evicted_id, e.from_protected, e.last);
                  $display("          got st %0d id %h prot %0b last %0b",
                           rsp_status, rsp_evicted_id, rsp_from_protected, rsp_last);
               end
            end
         end
      end
   end

   task automatic send_req(logic [2:0] kind, logic [31:0] id, logic [5:0] cnt);
      if (!calm && $urandom_range(99) < 35) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_block_id <= id;
      req_evict_count <= cnt;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_lru(kind, id, cnt);
      items_sent++;
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_promote(logic v);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      promote_on = v;
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_directed();
      send_req(slru_pkg::REQ_EVICT, '0, 6'd4);
      send_req(slru_pkg::REQ_INSERT, 32'h0000_0000, '0);
      send_req(slru_pkg::REQ_INSERT, 32'hFFFF_FFFF, 6'h3F);
      send_req(slru_pkg::REQ_INSERT, key_pool[0], '0);
      send_req(slru_pkg::REQ_INSERT, key_pool[0], '0);
      send_req(slru_pkg::REQ_ACCESS, key_pool[0], '0);
      send_req(slru_pkg::REQ_ACCESS, key_pool[0], '0);
      send_req(slru_pkg::REQ_TOUCH, 32'h0000_0000, '0);
      send_req(slru_pkg::REQ_ACCESS, 32'h1234_5678, '0);
      send_req(slru_pkg::REQ_TOUCH, 32'h8765_4321, '0);
      send_req(slru_pkg::REQ_EVICT, '0, 6'd0);
      send_req(slru_pkg::REQ_EVICT, '0, 6'd1);
      send_req(3'd5, key_pool[1], 6'd2);
      send_req(3'd6, '0, '0);
      send_req(3'd7, 32'hFFFF_FFFF, 6'h3F);
      send_req(slru_pkg::REQ_EVICT, '0, 6'd63);
      send_req(slru_pkg::REQ_INSERT, key_pool[2], '0);
      send_req(slru_pkg::REQ_CLEAR, '0, '0);
      send_req(slru_pkg::REQ_TOUCH, key_pool[2], '0);
      drain();
   endtask

   task automatic test_single_lru();
      write_promote(1'b0);
      for (int i = 0; i < 5; i++) send_req(slru_pkg::REQ_INSERT, key_pool[i], '0);
      send_req(slru_pkg::REQ_ACCESS, key_pool[1], '0);
      send_req(slru_pkg::REQ_TOUCH, key_pool[3], '0);
      send_req(slru_pkg::REQ_EVICT, '0, 6'd3);
      write_promote(1'b1);
      send_req(slru_pkg::REQ_INSERT, key_pool[6], '0);
      send_req(slru_pkg::REQ_EVICT, '0, 6'd32);
      drain();
   endtask

   task automatic test_random();
      int pick;
      logic [2:0]  kind;
      logic [31:0] id;
      for (int i = 0; i < 190; i++) begin
         if (i % 55 == 0 && i > 0) write_promote(1'($urandom_range(1)));
         calm = (i >= 95 && i < 130);
         pick = $urandom_range(99);
         if (pick < 38) kind = slru_pkg::REQ_INSERT;
         else if (pick < 60) kind = slru_pkg::REQ_ACCESS;
         else if (pick < 76) kind = slru_pkg::REQ_TOUCH;
         else if (pick < 93) kind = slru_pkg::REQ_EVICT;
         else if (pick < 96) kind = slru_pkg::REQ_CLEAR;
         else kind = 3'($urandom_range(5, 7));
         id = ($urandom_range(9) == 0) ? $urandom() : key_pool[$urandom_range(23)];
         send_req(kind, id, (pick < 90) ? 6'($urandom_range(0, 8)) : 6'($urandom_range(63)));
      end
      calm = 1'b0;
      drain();
   endtask

   initial begin
      promote_on = 1'b1;
      empty_lists();
      foreach (key_pool[i]) key_pool[i] = $urandom();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_single_lru();
      test_random();
      $display("sent %0d requests, checked %0d evicted blocks over both promote modes",
               items_sent, evicted_seen);
      if (errors == 0 && pending_rsp.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #12_000_000;
      $display("timeout with %0d beats outstanding", pending_rsp.size());
      $display("DONE: errors detected");
      $finish;
   end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/slru_pkg.sv
rtl/slru_ram.sv
rtl/segmented_lru_eviction.sv
rtl/slru_checker.sv
tb/sv/tb_top.sv
